[rtl/via_sp_pkg.sv]
// Shared constants, types and command/status structures of the via stack shortest path block.
package via_sp_pkg;

  localparam int NUM_LAYERS_DEF = 64;
  localparam int COST_BITS_DEF  = 16;
  localparam int TOTAL_BITS     = 24;
  localparam int MAX_HOPS       = 63;
  localparam int PATH_DEPTH     = MAX_HOPS + 1;
  localparam int HOP_BITS       = 7;
  localparam int LAYER_IN_BITS  = 6;
  localparam int VIA_BITS       = 6;
  localparam int COST_IN_BITS   = 16;

  localparam logic [1:0] FUNC_LINK  = 2'd0;
  localparam logic [1:0] FUNC_COST  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_INIT,
    OP_SEL,
    OP_SEL_END,
    OP_REL,
    OP_REL_END,
    OP_WALK_RD,
    OP_WALK_LK,
    OP_WALK_ST,
    OP_EM_RD,
    OP_EM_OUT,
    OP_MISS,
    OP_EMPTY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic same;
    logic out_range;
    logic scan_done;
    logic any;
    logic u_is_to;
    logic walk_end;
    logic too_long;
    logic n_zero;
  } stat_t;

endpackage

[rtl/via_sp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module via_sp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/via_sp_ctrl.sv]
// Controller state machine that sequences loads, the shortest path search and the hop output.
module via_sp_ctrl
  import via_sp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_func,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_QCHK    = 14'b00000000000100,
    S_INIT    = 14'b00000000001000,
    S_SEL     = 14'b00000000010000,
    S_SEL_END = 14'b00000000100000,
    S_REL     = 14'b00000001000000,
    S_REL_END = 14'b00000010000000,
    S_WALK_RD = 14'b00000100000000,
    S_WALK_LK = 14'b00001000000000,
    S_WALK_ST = 14'b00010000000000,
    S_EM_RD   = 14'b00100000000000,
    S_EM_OUT  = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   miss_r, miss_nxt;
  logic   empty_r, empty_nxt;

  always_comb begin
    state_nxt = state_r;
    miss_nxt  = miss_r;
    empty_nxt = empty_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_ACCEPT;
          if (in_func == FUNC_QUERY) begin
            state_nxt = S_QCHK;
          end
        end
      end
      S_QCHK: begin
        if (stat.same) begin
          empty_nxt = 1'b1;
          miss_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (stat.out_range) begin
          empty_nxt = 1'b0;
          miss_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.op = OP_SEL;
        if (stat.scan_done) begin
          state_nxt = S_SEL_END;
        end
      end
      S_SEL_END: begin
        cmd.op = OP_SEL_END;
        if (!stat.any) begin
          empty_nxt = 1'b0;
          miss_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.u_is_to) begin
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_REL;
        end
      end
      S_REL: begin
        cmd.op = OP_REL;
        if (stat.scan_done) begin
          state_nxt = S_REL_END;
        end
      end
      S_REL_END: begin
        cmd.op    = OP_REL_END;
        state_nxt = S_SEL;
      end
      S_WALK_RD: begin
        cmd.op    = OP_WALK_RD;
        state_nxt = S_WALK_LK;
      end
      S_WALK_LK: begin
        cmd.op    = OP_WALK_LK;
        state_nxt = S_WALK_ST;
      end
      S_WALK_ST: begin
        cmd.op = OP_WALK_ST;
        if (stat.too_long) begin
          empty_nxt = 1'b0;
          miss_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.walk_end) begin
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_EM_RD: begin
        cmd.op    = OP_EM_RD;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.op = OP_EM_OUT;
        if (stat.n_zero) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EM_RD;
        end
      end
      S_DONE: begin
        if (empty_r) begin
          cmd.op = OP_EMPTY;
        end else if (miss_r) begin
          cmd.op = OP_MISS;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      miss_r  <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      miss_r  <= miss_nxt;
      empty_r <= empty_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/via_sp_dp.sv]
// Datapath: link, cost, path-total, predecessor and hop memories with scan and walk logic.
module via_sp_dp
  import via_sp_pkg::*;
#(
  parameter int NUM_LAYERS = NUM_LAYERS_DEF,
  parameter int COST_BITS  = COST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic [1:0]               in_func,
  input  logic [LAYER_IN_BITS-1:0] in_layer_a,
  input  logic [LAYER_IN_BITS-1:0] in_layer_b,
  input  logic [VIA_BITS-1:0]      in_via_id,
  input  logic [COST_IN_BITS-1:0]  in_cost_value,
  output stat_t                    stat,
  output logic                     out_strobe,
  output logic [VIA_BITS-1:0]      out_hop_via,
  output logic                     out_found,
  output logic                     out_path_empty,
  output logic                     out_last
);

  localparam int LW       = $clog2(NUM_LAYERS);
  localparam int XW       = (LW > LAYER_IN_BITS) ? LW : LAYER_IN_BITS;
  localparam int CW       = XW + 1;
  localparam int SCW      = LW + 1;
  localparam int LINK_AW  = 2 * LW;
  localparam int LINK_DEP = 1 << LINK_AW;
  localparam int LINK_W   = VIA_BITS + 1;
  localparam int SUMW     = ((COST_BITS > TOTAL_BITS) ? COST_BITS : TOTAL_BITS) + 1;
  localparam int PATH_AW  = $clog2(PATH_DEPTH);

  function automatic logic [LINK_AW-1:0] pair_addr(input logic [LW-1:0] x,
                                                   input logic [LW-1:0] y);
    logic [LW-1:0] lo;
    logic [LW-1:0] hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    return {lo, hi};
  endfunction

  // Latched query ends.
  logic [XW-1:0] qa_r, qb_r;
  logic [XW-1:0] a_x, b_x, lo_x, hi_x;
  logic [LW-1:0] from_c, to_c;

  // Scan pipeline.
  logic [SCW-1:0] scan_r;
  logic           pend_r;
  logic [LW-1:0]  vd_r;
  logic           any_r;
  logic [LW-1:0]  u_r;
  logic [TOTAL_BITS-1:0] ucost_r;

  logic [NUM_LAYERS-1:0] settled_r, reached_r, costv_r;

  // Path walk.
  logic [LW-1:0]       walk_u_r, wp_r;
  logic [HOP_BITS-1:0] n_r;

  logic [LINK_AW-1:0] clr_r;

  // Memory ports.
  logic                  link_we;
  logic [LINK_AW-1:0]    link_wa, link_ra;
  logic [LINK_W-1:0]     link_wd, link_q;
  logic                  cost_we;
  logic [COST_BITS-1:0]  cost_q;
  logic                  best_we;
  logic [LW-1:0]         best_wa;
  logic [TOTAL_BITS-1:0] best_wd, best_q;
  logic                  prev_we;
  logic [LW-1:0]         prev_wd, prev_q;
  logic                  path_we;
  logic [PATH_AW-1:0]    path_ra;
  logic [VIA_BITS-1:0]   path_q;

  logic                  a_ok, b_ok, issue;
  logic [SUMW-1:0]       sum;
  logic [TOTAL_BITS-1:0] total;
  logic                  link_ok, upd, cand;
  logic [HOP_BITS-1:0]   n_dec;

  assign a_x    = XW'(in_layer_a);
  assign b_x    = XW'(in_layer_b);
  // Compared one bit wider so that a layer count equal to 2^XW still fits.
  assign a_ok   = (CW'(a_x) < CW'(NUM_LAYERS));
  assign b_ok   = (CW'(b_x) < CW'(NUM_LAYERS));
  assign lo_x   = (qa_r < qb_r) ? qa_r : qb_r;
  assign hi_x   = (qa_r < qb_r) ? qb_r : qa_r;
  assign from_c = lo_x[LW-1:0];
  assign to_c   = hi_x[LW-1:0];
  assign issue  = (scan_r != SCW'(NUM_LAYERS));
  assign n_dec  = n_r - HOP_BITS'(1);

  // Relaxation of one neighbour; an unwritten cost entry reads as zero.
  assign sum     = SUMW'(ucost_r) + SUMW'(costv_r[vd_r] ? cost_q : '0);
  assign total   = (sum > SUMW'({TOTAL_BITS{1'b1}})) ? {TOTAL_BITS{1'b1}}
                                                     : sum[TOTAL_BITS-1:0];
  assign link_ok = link_q[VIA_BITS] && (vd_r != u_r) && !settled_r[vd_r];
  assign upd     = pend_r && link_ok && (!reached_r[vd_r] || (total < best_q));
  assign cand    = pend_r && reached_r[vd_r] && !settled_r[vd_r] &&
                   (!any_r || (best_q < ucost_r));

  always_comb begin
    link_we = 1'b0;
    link_wa = pair_addr(a_x[LW-1:0], b_x[LW-1:0]);
    link_wd = {1'b1, in_via_id};
    if (cmd.op == OP_CLEAR) begin
      link_we = 1'b1;
      link_wa = clr_r;
      link_wd = '0;
    end else if (cmd.op == OP_ACCEPT && in_func == FUNC_LINK && a_ok && b_ok) begin
      link_we = 1'b1;
    end
  end

  assign link_ra = (cmd.op == OP_WALK_LK) ? pair_addr(prev_q, walk_u_r)
                                          : pair_addr(u_r, scan_r[LW-1:0]);
  assign cost_we = (cmd.op == OP_ACCEPT) && (in_func == FUNC_COST) && a_ok;

  always_comb begin
    best_we = 1'b0;
    best_wa = vd_r;
    best_wd = total;
    prev_we = 1'b0;
    prev_wd = u_r;
    if (cmd.op == OP_INIT) begin
      best_we = 1'b1;
      best_wa = from_c;
      best_wd = '0;
      prev_we = 1'b1;
      prev_wd = from_c;
    end else if (cmd.op == OP_REL && upd) begin
      best_we = 1'b1;
      prev_we = 1'b1;
    end
  end

  assign path_we = (cmd.op == OP_WALK_ST);
  assign path_ra = n_dec[PATH_AW-1:0];

  via_sp_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEP)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(link_ra), .rdata(link_q)
  );

  via_sp_ram #(.WIDTH(COST_BITS), .DEPTH(NUM_LAYERS)) u_cost (
    .clk(clk), .we(cost_we), .waddr(a_x[LW-1:0]), .wdata(COST_BITS'(in_cost_value)),
    .raddr(scan_r[LW-1:0]), .rdata(cost_q)
  );

  via_sp_ram #(.WIDTH(TOTAL_BITS), .DEPTH(NUM_LAYERS)) u_best (
    .clk(clk), .we(best_we), .waddr(best_wa), .wdata(best_wd),
    .raddr(scan_r[LW-1:0]), .rdata(best_q)
  );

  via_sp_ram #(.WIDTH(LW), .DEPTH(NUM_LAYERS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(best_wa), .wdata(prev_wd),
    .raddr(walk_u_r), .rdata(prev_q)
  );

  via_sp_ram #(.WIDTH(VIA_BITS), .DEPTH(PATH_DEPTH)) u_path (
    .clk(clk), .we(path_we), .waddr(n_r[PATH_AW-1:0]), .wdata(link_q[VIA_BITS-1:0]),
    .raddr(path_ra), .rdata(path_q)
  );

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      pend_r     <= 1'b0;
      settled_r  <= '0;
      reached_r  <= '0;
      costv_r    <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (cmd.op == OP_EM_OUT) || (cmd.op == OP_MISS) || (cmd.op == OP_EMPTY);
      if (cmd.op == OP_CLEAR) begin
        clr_r <= clr_r + LINK_AW'(1);
      end
      if (cost_we) begin
        costv_r[a_x[LW-1:0]] <= 1'b1;
      end
      if (cmd.op == OP_SEL || cmd.op == OP_REL) begin
        pend_r <= issue;
      end else begin
        pend_r <= 1'b0;
      end
      if (cmd.op == OP_INIT) begin
        settled_r <= '0;
        reached_r <= {{(NUM_LAYERS-1){1'b0}}, 1'b1} << from_c;
      end
      if (cmd.op == OP_SEL_END && any_r) begin
        settled_r[u_r] <= 1'b1;
      end
      if (cmd.op == OP_REL && upd) begin
        reached_r[vd_r] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      qa_r <= a_x;
      qb_r <= b_x;
    end
    if (cmd.op == OP_INIT || cmd.op == OP_SEL_END || cmd.op == OP_REL_END) begin
      scan_r <= '0;
    end else if ((cmd.op == OP_SEL || cmd.op == OP_REL) && issue) begin
      scan_r <= scan_r + SCW'(1);
    end
    if ((cmd.op == OP_SEL || cmd.op == OP_REL) && issue) begin
      vd_r <= scan_r[LW-1:0];
    end
    if (cmd.op == OP_INIT || cmd.op == OP_REL_END) begin
      any_r <= 1'b0;
    end else if (cmd.op == OP_SEL && cand) begin
      any_r   <= 1'b1;
      u_r     <= vd_r;
      ucost_r <= best_q;
    end
    if (cmd.op == OP_SEL_END) begin
      walk_u_r <= to_c;
      n_r      <= '0;
    end
    if (cmd.op == OP_WALK_LK) begin
      wp_r <= prev_q;
    end
    if (cmd.op == OP_WALK_ST) begin
      n_r      <= n_r + HOP_BITS'(1);
      walk_u_r <= wp_r;
    end
    if (cmd.op == OP_EM_RD) begin
      n_r <= n_dec;
    end
    if (cmd.op == OP_EM_OUT) begin
      out_hop_via    <= path_q;
      out_found      <= 1'b1;
      out_path_empty <= 1'b0;
      out_last       <= (n_r == '0);
    end else if (cmd.op == OP_MISS) begin
      out_hop_via    <= '0;
      out_found      <= 1'b0;
      out_path_empty <= 1'b0;
      out_last       <= 1'b1;
    end else if (cmd.op == OP_EMPTY) begin
      out_hop_via    <= '0;
      out_found      <= 1'b1;
      out_path_empty <= 1'b1;
      out_last       <= 1'b1;
    end
  end

  assign stat.clr_last  = &clr_r;
  assign stat.same      = (qa_r == qb_r);
  assign stat.out_range = (CW'(qa_r) >= CW'(NUM_LAYERS)) || (CW'(qb_r) >= CW'(NUM_LAYERS));
  assign stat.scan_done = !issue && !pend_r;
  assign stat.any       = any_r;
  assign stat.u_is_to   = (u_r == to_c);
  assign stat.walk_end  = (wp_r == from_c);
  assign stat.too_long  = (n_r == HOP_BITS'(MAX_HOPS));
  assign stat.n_zero    = (n_r == '0);

endmodule

[rtl/via_stack_shortest_path_core.sv]
// Top level of the via stack shortest path block: controller and datapath.
//
// Commands enter on start/busy: a command is transferred at a rising edge with start high
// and busy low. in_func selects a link load, a layer cost load or a path query.
// Loads give no result. A query searches from the lower-numbered end
// to the higher one, then gives one result per hop in order from the lower end, each
// shown for one cycle with out_strobe high and out_last on the final hop. A same-layer
// query gives one result with out_path_empty set; no path gives one with out_found clear.
// Each layer that a query settles costs one total-memory scan for the minimum and one
// link/cost/total scan to relax its neighbours. The walk back passes through the read,
// lookup and store states per hop, and the output through the read and output states.
// The single read port of the path-total memory sets the scan rate.
// After reset the link memory is swept to invalid, one entry per cycle, through all
// 2^(2*ceil(log2(NUM_LAYERS))) entries (4096 for 64 layers) with busy high; layer costs
// read as zero until loaded. The receiver cannot stall: every strobed result is taken.
module via_stack_shortest_path_core
  import via_sp_pkg::*;
#(
  parameter int NUM_LAYERS = NUM_LAYERS_DEF,
  parameter int COST_BITS  = COST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_func,
  input  logic [LAYER_IN_BITS-1:0] in_layer_a,
  input  logic [LAYER_IN_BITS-1:0] in_layer_b,
  input  logic [VIA_BITS-1:0]      in_via_id,
  input  logic [COST_IN_BITS-1:0]  in_cost_value,
  output logic                     out_strobe,
  output logic [VIA_BITS-1:0]      out_hop_via,
  output logic                     out_found,
  output logic                     out_path_empty,
  output logic                     out_last
);

  cmd_t  cmd;
  stat_t stat;

  via_sp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_func(in_func),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  via_sp_dp #(.NUM_LAYERS(NUM_LAYERS), .COST_BITS(COST_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_func(in_func),
    .in_layer_a(in_layer_a), .in_layer_b(in_layer_b), .in_via_id(in_via_id),
    .in_cost_value(in_cost_value), .stat(stat),
    .out_strobe(out_strobe), .out_hop_via(out_hop_via), .out_found(out_found),
    .out_path_empty(out_path_empty), .out_last(out_last)
  );

endmodule

[verif/via_stack_shortest_path_core_tb.sv]
// Self-checking testbench for the via stack shortest path core: directed and random commands.
module via_stack_shortest_path_core_tb
  import via_sp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NL = 64;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  layer_a;
    logic [5:0]  layer_b;
    logic [5:0]  via_id;
    logic [15:0] cost_value;
  } cmd_item_t;

  typedef struct packed {
    logic [5:0] hop_via;
    logic       found;
    logic       path_empty;
    logic       last;
  } hop_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [5:0] in_layer_a = '0;
  logic [5:0] in_layer_b = '0;
  logic [5:0] in_via_id = '0;
  logic [15:0] in_cost_value = '0;
  logic out_strobe;
  logic [5:0] out_hop_via;
  logic out_found, out_path_empty, out_last;

  via_stack_shortest_path_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_layer_a(in_layer_a), .in_layer_b(in_layer_b),
    .in_via_id(in_via_id), .in_cost_value(in_cost_value),
    .out_strobe(out_strobe), .out_hop_via(out_hop_via), .out_found(out_found),
    .out_path_empty(out_path_empty), .out_last(out_last)
  );

  always #10 clk = ~clk;

  // Predictor state.
  logic [6:0]  link_mem [NL*NL];
  logic [15:0] layer_cost [NL];

  cmd_item_t pending_cmds[$];
  hop_t      expected_hops[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        gap_left = 0;
  bit        hold_for_drain = 1'b0;
  bit        stim_done = 1'b0;

  function automatic int pair_slot(int x, int y);
    return (x < y) ? x * NL + y : y * NL + x;
  endfunction

  function automatic void push_hop(logic [5:0] v, logic f, logic e, logic l);
    hop_t h;
    h.hop_via = v; h.found = f; h.path_empty = e; h.last = l;
    expected_hops = {expected_hops, h};
  endfunction

  function automatic void add_cmd(cmd_item_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  task automatic predict_route(cmd_item_t c);
    int from, to, u, n;
    logic [23:0] path_total [NL];
    int prev [NL];
    bit done [NL];
    bit seen [NL];
    int route [NL+1];
    bit any;
    logic [24:0] total;
    if (c.func == FUNC_LINK) begin
      link_mem[pair_slot(c.layer_a, c.layer_b)] = {1'b1, c.via_id};
    end else if (c.func == FUNC_COST) begin
      layer_cost[c.layer_a] = c.cost_value;
    end else if (c.func == FUNC_QUERY) begin
      if (c.layer_a == c.layer_b) begin
        push_hop('0, 1'b1, 1'b1, 1'b1);
        return;
      end
      from = (c.layer_a < c.layer_b) ? c.layer_a : c.layer_b;
      to = (c.layer_a < c.layer_b) ? c.layer_b : c.layer_a;
      for (int i = 0; i < NL; i++) begin
        done[i] = 0; seen[i] = 0; path_total[i] = '0; prev[i] = 0;
      end
      seen[from] = 1;
      prev[from] = from;
      forever begin
        any = 0; u = 0;
        for (int v = 0; v < NL; v++)
          if (seen[v] && !done[v] && (!any || path_total[v] < path_total[u])) begin
            u = v; any = 1;
          end
        if (!any) break;
        done[u] = 1;
        if (u == to) break;
        for (int v = 0; v < NL; v++) begin
          if (v == u || done[v] || !link_mem[pair_slot(u, v)][6]) continue;
          total = {1'b0, path_total[u]} + 25'(layer_cost[v]);
          if (total > 25'hFFFFFF) total = 25'hFFFFFF;
          if (!seen[v] || total[23:0] < path_total[v]) begin
            seen[v] = 1; path_total[v] = total[23:0]; prev[v] = u;
          end
        end
      end
      if (!seen[to]) begin
        push_hop('0, 1'b0, 1'b0, 1'b1);
        return;
      end
      n = 0; u = to;
      while (u != from && n < NL) begin
        route[n] = u; n++; u = prev[u];
      end
      if (u != from || n == 0 || n > MAX_HOPS) begin
        push_hop('0, 1'b0, 1'b0, 1'b1);
        return;
      end
      route[n] = from;
      for (int i = n; i > 0; i--)
        push_hop(link_mem[pair_slot(route[i], route[i-1])][5:0], 1'b1, 1'b0, i == 1);
    end
  endtask

  function automatic cmd_item_t make_cmd(logic [1:0] f, int a, int b, int v, int cv);
    cmd_item_t c;
    c.func = f; c.layer_a = 6'(a); c.layer_b = 6'(b); c.via_id = 6'(v);
    c.cost_value = 16'(cv);
    return c;
  endfunction

  // Driver: random gaps, and one pause until every expected result has come.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_route({in_func, in_layer_a, in_layer_b, in_via_id, in_cost_value});
      end
      if (start && busy) begin
        // Hold the command until it is transferred.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (hold_for_drain && (expected_hops.size() != 0 || (start && !busy))) begin
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd_item_t c;
        c = pending_cmds.pop_front();
        hold_for_drain <= 1'b0;
        start <= 1'b1;
        in_func <= c.func; in_layer_a <= c.layer_a; in_layer_b <= c.layer_b;
        in_via_id <= c.via_id; in_cost_value <= c.cost_value;
        if ($urandom_range(0, 3) == 0)
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
                      $urandom_range(1, 3);
        if (pending_cmds.size() == 70) hold_for_drain <= 1'b1;
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_hops.size() == 0) begin
          $error("unexpected result hop_via=%0d", out_hop_via);
          fail_count++;
        end else begin
          hop_t e;
          e = expected_hops.pop_front();
          if (out_hop_via !== e.hop_via) begin
            $error("hop_via expected %0d actual %0d", e.hop_via, out_hop_via);
            fail_count++;
          end
          if (out_found !== e.found) begin
            $error("found expected %0d actual %0d", e.found, out_found);
            fail_count++;
          end
          if (out_path_empty !== e.path_empty) begin
            $error("path_empty expected %0d actual %0d", e.path_empty, out_path_empty);
            fail_count++;
          end
          if (out_last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, out_last);
            fail_count++;
          end
        end
      end
      if (out_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("[via_stack_shortest_path_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int lo, hi;
    for (int i = 0; i < NL*NL; i++) link_mem[i] = '0;
    for (int i = 0; i < NL; i++) layer_cost[i] = '0;
    // Directed: same layer, unreachable, chain with ties, unused code.
    add_cmd(make_cmd(FUNC_QUERY, 5, 5, 0, 0));
    add_cmd(make_cmd(FUNC_QUERY, 0, 63, 0, 0));
    add_cmd(make_cmd(FUNC_LINK, 0, 1, 63, 0));
    add_cmd(make_cmd(FUNC_LINK, 2, 1, 42, 0));
    add_cmd(make_cmd(FUNC_LINK, 0, 2, 21, 0));
    add_cmd(make_cmd(FUNC_LINK, 7, 7, 9, 0));
    add_cmd(make_cmd(FUNC_QUERY, 2, 0, 0, 0));
    add_cmd(make_cmd(FUNC_COST, 2, 0, 0, 16'hFFFF));
    add_cmd(make_cmd(FUNC_QUERY, 0, 2, 0, 0));
    add_cmd(make_cmd(FUNC_LINK, 2, 63, 0, 0));
    add_cmd(make_cmd(FUNC_COST, 63, 0, 0, 16'hFFFF));
    add_cmd(make_cmd(FUNC_QUERY, 63, 0, 0, 0));
    add_cmd(make_cmd(FUNC_QUERY, 7, 7, 0, 0));
    add_cmd(make_cmd(2'd3, 63, 63, 63, 16'hFFFF));
    add_cmd(make_cmd(FUNC_COST, 2, 0, 0, 0));
    add_cmd(make_cmd(FUNC_QUERY, 1, 63, 0, 0));
    // Random: link loads, costs, queries and unused codes, in a small cluster, then layers 40-63.
    for (int i = 0; i < 125; i++) begin
      int r;
      r = $urandom_range(0, 9);
      lo = (i < 60) ? 0 : 40;
      hi = (i < 60) ? 15 : 63;
      if (r < 4)
        add_cmd(make_cmd(FUNC_LINK, $urandom_range(lo, hi),
          $urandom_range(lo, hi), $urandom_range(0, 63), $urandom));
      else if (r < 6)
        add_cmd(make_cmd(FUNC_COST, $urandom_range(lo, hi), $urandom,
          $urandom, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20)));
      else if (r < 9)
        add_cmd(make_cmd(FUNC_QUERY, $urandom_range(lo, hi),
          $urandom_range(lo, hi), $urandom, $urandom));
      else
        add_cmd(make_cmd(2'd3, $urandom, $urandom, $urandom, $urandom));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_hops.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_hops.size() == 0) begin
      $display("[via_stack_shortest_path_core] OK");
    end else begin
      $display("[via_stack_shortest_path_core] ERROR");
    end
    $finish;
  end

endmodule
